// ----- rtl/cppr_pkg.sv -----
// Shared types for the closest prime pair block.
// Holds the controller-to-datapath command and status structs and the field width.
// No dependencies.
package cppr_pkg;

    localparam int FieldW = 16;

    typedef struct packed {
        logic load;        // capture the query bounds
        logic fill;        // write one sieve entry, set as candidate prime from 2 up
        logic rd_i;        // read the sieve entry of the current base
        logic adv_i;       // step the base and its square
        logic mark_start;  // begin crossing out at the square of the base
        logic mark;        // cross out one multiple
        logic scan_init;   // prepare the range scan
        logic scan;        // run the range scan
        logic out_load;    // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic fill_last;   // last entry of the fill
        logic sieve_end;   // square of the base past the upper bound
        logic is_prime;    // read data of the base entry
        logic mark_last;   // next multiple lies past the upper bound
        logic scan_done;   // range scan finished or stopped early
        logic out_free;    // output register can take a result
    } sts_t;

endpackage

// ----- rtl/closest_prime_pair_in_range.sv -----
// Closest pair of consecutive primes in [low_bound, high_bound]. Each query rebuilds a
// Sieve of Eratosthenes bitmap for 0..high_bound (saturated to LIMIT-1) in a single-port
// RAM, then scans the range upward and returns the pair with the smallest gap, earliest
// on ties, stopping at the first pair with a gap of 2 or less; found is 0 with zero primes
// when the range holds fewer than two primes. One query at a time. After the accepting
// edge the query fills the bitmap, reads and checks each sieve base up to sqrt(hi),
// crosses out the multiples of each prime base from its square, starts the scan, scans
// the range and loads the output register. The single RAM port, one access per cycle,
// serialises these steps. A new query is taken while the previous result still waits
// in the output register.
// Depends on cppr_pkg, cppr_ctrl, cppr_dp and cppr_ram.
module closest_prime_pair_in_range import cppr_pkg::*; #(
    parameter int LIMIT = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FieldW-1:0] s_low_bound,
    input  logic [FieldW-1:0] s_high_bound,
    output logic              m_valid,
    input  logic              m_ready,
    output logic              m_found,
    output logic [FieldW-1:0] m_first_prime,
    output logic [FieldW-1:0] m_second_prime
);

    cmd_t cmd;
    sts_t sts;

    cppr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    cppr_dp #(
        .LIMIT (LIMIT)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_low_bound    (s_low_bound),
        .s_high_bound   (s_high_bound),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .sts            (sts),
        .m_valid        (m_valid),
        .m_found        (m_found),
        .m_first_prime  (m_first_prime),
        .m_second_prime (m_second_prime)
    );

endmodule

// ----- rtl/cppr_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module cppr_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 65536
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- rtl/cppr_ctrl.sv -----
// Sequencing state machine for the closest prime pair block.
// Depends on cppr_pkg for the command and status structs.
module cppr_ctrl import cppr_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_FILL   = 7'b0000010,
        ST_CHK_RD = 7'b0000100,
        ST_CHK_EV = 7'b0001000,
        ST_MARK   = 7'b0010000,
        ST_SCAN   = 7'b0100000,
        ST_DONE   = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_FILL;
                end
            end
            ST_FILL: begin
                cmd.fill = 1'b1;
                if (sts.fill_last) begin
                    state_next = ST_CHK_RD;
                end
            end
            ST_CHK_RD: begin
                if (sts.sieve_end) begin
                    cmd.scan_init = 1'b1;
                    state_next    = ST_SCAN;
                end else begin
                    cmd.rd_i   = 1'b1;
                    state_next = ST_CHK_EV;
                end
            end
            ST_CHK_EV: begin
                if (sts.is_prime) begin
                    cmd.mark_start = 1'b1;
                    state_next     = ST_MARK;
                end else begin
                    cmd.adv_i  = 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_MARK: begin
                cmd.mark = 1'b1;
                if (sts.mark_last) begin
                    cmd.adv_i  = 1'b1;
                    state_next = ST_CHK_RD;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_ready = (state_reg == ST_IDLE);

endmodule

// ----- rtl/cppr_dp.sv -----
// Datapath for the closest prime pair block: bounds, sieve counters, scan and result.
// Depends on cppr_pkg and instantiates cppr_ram for the sieve bitmap.
module cppr_dp import cppr_pkg::*; #(
    parameter int LIMIT = 65536
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [FieldW-1:0] s_low_bound,
    input  logic [FieldW-1:0] s_high_bound,
    input  logic              m_ready,
    input  cmd_t              cmd,
    output sts_t              sts,
    output logic              m_valid,
    output logic              m_found,
    output logic [FieldW-1:0] m_first_prime,
    output logic [FieldW-1:0] m_second_prime
);

    localparam int AW = $clog2(LIMIT);
    localparam int NW = ((AW > FieldW) ? AW : FieldW) + 1;
    localparam logic [NW-1:0] MaxIdx = NW'(LIMIT - 1);

    logic [NW-1:0] lo_reg, hi_reg, idx_reg, i_reg, sq_reg;
    logic [NW-1:0] n_reg, pend_n_reg, prev_reg;
    logic [NW-1:0] best_a_reg, best_b_reg, best_gap_reg;
    logic          pend_reg, have_prev_reg, have_pair_reg;
    logic          m_valid_reg, m_found_reg;
    logic [FieldW-1:0] m_first_reg, m_second_reg;

    logic [NW-1:0] hi_in, hi_sat, idx_plus_i, gap, new_gap;
    logic          issue, eval, take, stop;

    logic          ram_we, ram_wdata, ram_rdata;
    logic [AW-1:0] ram_addr;

    assign hi_in  = NW'(s_high_bound);
    assign hi_sat = (hi_in > MaxIdx) ? MaxIdx : hi_in;

    assign idx_plus_i = idx_reg + i_reg;

    // Scan pipeline: issue address n, evaluate the entry of the previous issue.
    assign issue   = cmd.scan && (n_reg <= hi_reg);
    assign eval    = cmd.scan && pend_reg && ram_rdata;
    assign gap     = pend_n_reg - prev_reg;
    assign take    = eval && have_prev_reg && (!have_pair_reg || (gap < best_gap_reg));
    assign new_gap = take ? gap : best_gap_reg;
    assign stop    = eval && have_prev_reg && (new_gap <= NW'(2));

    always_comb begin
        sts.fill_last = (idx_reg == hi_reg);
        sts.sieve_end = (sq_reg > hi_reg);
        sts.is_prime  = ram_rdata;
        sts.mark_last = (idx_plus_i > hi_reg);
        sts.scan_done = stop || (!pend_reg && (n_reg > hi_reg));
        sts.out_free  = !m_valid_reg || m_ready;
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = n_reg[AW-1:0];
        priority if (cmd.fill) begin
            ram_we    = 1'b1;
            ram_addr  = idx_reg[AW-1:0];
            ram_wdata = (idx_reg >= NW'(2));
        end else if (cmd.mark) begin
            ram_we   = 1'b1;
            ram_addr = idx_reg[AW-1:0];
        end else if (cmd.rd_i) begin
            ram_addr = i_reg[AW-1:0];
        end else begin
            ram_addr = n_reg[AW-1:0];
        end
    end

    cppr_ram #(
        .WIDTH (1),
        .DEPTH (LIMIT)
    ) u_prime_map (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.scan_init) begin
                pend_reg <= 1'b0;
            end else if (cmd.scan) begin
                pend_reg <= issue;
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            lo_reg  <= NW'(s_low_bound);
            hi_reg  <= hi_sat;
            idx_reg <= '0;
        end
        if (cmd.fill) begin
            idx_reg <= idx_reg + NW'(1);
            if (sts.fill_last) begin
                i_reg  <= NW'(2);
                sq_reg <= NW'(4);
            end
        end
        if (cmd.mark_start) begin
            idx_reg <= sq_reg;
        end
        if (cmd.mark) begin
            idx_reg <= idx_plus_i;
        end
        // (i+1)^2 = i^2 + 2i + 1
        if (cmd.adv_i) begin
            i_reg  <= i_reg + NW'(1);
            sq_reg <= sq_reg + {i_reg[NW-2:0], 1'b1};
        end
        if (cmd.scan_init) begin
            n_reg         <= lo_reg;
            have_prev_reg <= 1'b0;
            have_pair_reg <= 1'b0;
        end
        if (issue) begin
            n_reg      <= n_reg + NW'(1);
            pend_n_reg <= n_reg;
        end
        if (eval) begin
            prev_reg      <= pend_n_reg;
            have_prev_reg <= 1'b1;
            if (take) begin
                best_a_reg    <= prev_reg;
                best_b_reg    <= pend_n_reg;
                best_gap_reg  <= gap;
                have_pair_reg <= 1'b1;
            end
        end
        if (cmd.out_load) begin
            m_found_reg  <= have_pair_reg;
            m_first_reg  <= have_pair_reg ? best_a_reg[FieldW-1:0] : '0;
            m_second_reg <= have_pair_reg ? best_b_reg[FieldW-1:0] : '0;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_found        = m_found_reg;
    assign m_first_prime  = m_first_reg;
    assign m_second_prime = m_second_reg;

endmodule

// ----- test/tb_closest_prime_pair_in_range.sv -----
`timescale 1ns / 1ps
// Testbench for closest_prime_pair_in_range: range queries against a local prime table.
// Depends on cppr_pkg and the closest_prime_pair_in_range RTL.
module tb_closest_prime_pair_in_range;
    import cppr_pkg::*;

    localparam int CycleLimit = 5_000_000;
    localparam int HoldCycles = 3000;

    typedef struct packed {
        logic              found;
        logic [FieldW-1:0] lo_prime;
        logic [FieldW-1:0] hi_prime;
    } pair_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [FieldW-1:0] s_low_bound = 16'd1;
    logic [FieldW-1:0] s_high_bound = 16'd1;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_found;
    logic [FieldW-1:0] m_first_prime;
    logic [FieldW-1:0] m_second_prime;

    bit    is_prime [0:65535];
    pair_t pending_pairs [$];
    int    mismatches = 0;
    int    cycle_count = 0;
    int    hold_left = 0;
    bit    steady = 1'b0;

    closest_prime_pair_in_range u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_low_bound   (s_low_bound),
        .s_high_bound  (s_high_bound),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_found       (m_found),
        .m_first_prime (m_first_prime),
        .m_second_prime(m_second_prime)
    );

    always #6 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Primality does not depend on the query's upper bound, so one table serves all.
    function automatic void sieve_primes();
        int i;
        int j;
        for (i = 0; i < 65536; i++)
            is_prime[i] = (i >= 2);
        for (i = 2; i * i < 65536; i++) begin
            if (is_prime[i]) begin
                for (j = i * i; j < 65536; j += i)
                    is_prime[j] = 1'b0;
            end
        end
    endfunction

    function automatic pair_t closest_pair(input logic [FieldW-1:0] lo,
                                           input logic [FieldW-1:0] hi);
        pair_t r;
        int    n;
        int    prev;
        int    gap;
        int    best_gap;
        bit    have_prev;
        r = '0;
        prev = 0;
        best_gap = 0;
        have_prev = 1'b0;
        for (n = int'(lo); n <= int'(hi); n++) begin
            if (!is_prime[n])
                continue;
            if (have_prev) begin
                gap = n - prev;
                if (!r.found || gap < best_gap) begin
                    r.found = 1'b1;
                    r.lo_prime = prev[FieldW-1:0];
                    r.hi_prime = n[FieldW-1:0];
                    best_gap = gap;
                end
                // nothing later can beat a gap of 2
                if (best_gap <= 2)
                    break;
            end
            prev = n;
            have_prev = 1'b1;
        end
        return r;
    endfunction

    // Mostly short gaps, a few long ones.
    function automatic int idle_len();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    task automatic send_query(input logic [FieldW-1:0] lo, input logic [FieldW-1:0] hi);
        int gap;
        gap = steady ? 0 : idle_len();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_low_bound <= lo;
        s_high_bound <= hi;
        do @(posedge aclk); while (!s_ready);
        pending_pairs.push_back(closest_pair(lo, hi));
    endtask

    // Receiver: random stalls, plus a long hold-off when one is requested.
    initial begin
        int idle_left;
        idle_left = 0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else if (idle_left > 0) begin
                m_ready <= 1'b0;
                idle_left--;
            end else begin
                m_ready <= 1'b1;
                idle_left = steady ? 0 : idle_len();
            end
        end
    end

    always @(posedge aclk) begin
        pair_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_pairs.size() == 0) begin
                $display("%0t: expected no result, got found=%0d first=%0d second=%0d",
                         $time, m_found, m_first_prime, m_second_prime);
                mismatches++;
            end else begin
                want = pending_pairs.pop_front();
                if (m_found !== want.found) begin
                    $display("%0t: found expected %0d got %0d", $time, want.found, m_found);
                    mismatches++;
                end
                if (m_first_prime !== want.lo_prime) begin
                    $display("%0t: first_prime expected %0d got %0d",
                             $time, want.lo_prime, m_first_prime);
                    mismatches++;
                end
                if (m_second_prime !== want.hi_prime) begin
                    $display("%0t: second_prime expected %0d got %0d",
                             $time, want.hi_prime, m_second_prime);
                    mismatches++;
                end
            end
        end
    end

    task automatic test_directed();
        steady = 1'b1;
        send_query(16'd1, 16'd1);        // zero and one only
        send_query(16'd1, 16'd2);        // a single prime
        send_query(16'd2, 16'd3);        // gap of one
        send_query(16'd1, 16'd10);
        send_query(16'd3, 16'd10);
        send_query(16'd8, 16'd10);       // no primes at all
        send_query(16'd24, 16'd28);
        send_query(16'd23, 16'd29);      // both ends prime, one wide gap
        send_query(16'd90, 16'd96);
        send_query(16'd47, 16'd60);      // tie on gap 6, earliest wins
        send_query(16'd199, 16'd226);    // tie on gap 12
        send_query(16'd113, 16'd140);    // uneven gaps, stop on twin pair
        send_query(16'd20, 16'd1);       // empty range
        send_query(16'hFFFF, 16'd1);
        send_query(16'hFFFF, 16'hFFFF);
        send_query(16'd65500, 16'hFFFF); // full-size sieve
        send_query(16'd32700, 16'd32800);
        steady = 1'b0;
    endtask

    task automatic test_random();
        logic [FieldW-1:0] lo;
        logic [FieldW-1:0] hi;
        int                pick;
        for (int k = 0; k < 80; k++) begin
            // hold the first stretch free of gaps
            steady = (k < 15);
            pick = $urandom_range(99);
            if (pick < 2)
                hi = FieldW'($urandom_range(1000, 4000));
            else
                hi = FieldW'($urandom_range(1, 300));
            if (pick >= 90)
                lo = FieldW'($urandom_range(hi, 65535));
            else
                lo = FieldW'($urandom_range(1, hi));
            send_query(lo, hi);
        end
        steady = 1'b0;
    endtask

    task automatic test_backpressure();
        logic [FieldW-1:0] hi;
        @(negedge aclk);
        hold_left = HoldCycles;
        steady = 1'b1;
        for (int k = 0; k < 6; k++) begin
            hi = FieldW'($urandom_range(2, 60));
            send_query(FieldW'($urandom_range(1, hi)), hi);
        end
        steady = 1'b0;
    endtask

    initial begin
        sieve_primes();
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;
        test_directed();
        test_random();
        test_backpressure();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_pairs.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
